FILE: hw/rtl/magic_sync_frame_deframer_crc16_defines.svh
// Assertion macros shared by the deframer RTL files.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MAGIC_SYNC_FRAME_DEFRAMER_CRC16_DEFINES_SVH
`define MAGIC_SYNC_FRAME_DEFRAMER_CRC16_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

FILE: hw/rtl/msfd_pkg.sv
// Shared types, constants and the byte-wide CRC function of the deframer.
// No dependencies; used by msfd_out_skid and magic_sync_frame_deframer_crc16.
package msfd_pkg;

	localparam logic [7:0]  MAGIC_FIRST   = 8'hA5;
	localparam logic [7:0]  MAGIC_SECOND  = 8'h5A;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_TOP       = 16'h8000;
	localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2,
		KIND_ABANDON = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] index;
		logic [7:0]  command;
		logic [7:0]  seq_num;
		logic [15:0] length;
	} result_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first, eight shift steps.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/msfd_out_skid.sv
// Two-entry output stage: a result register backed by a skid register.
// Depends on msfd_pkg for result_t and on the shared assertion macro header.
`include "magic_sync_frame_deframer_crc16_defines.svh"

module msfd_out_skid
	import msfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_valid_q;
	result_t main_q;
	logic    skid_valid_q;
	result_t skid_q;

	// Control: the main register refills from the skid first, then from a new push.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers follow the same selection and need no reset.
	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = main_q;

	`MSFD_ASSERT_IMP(a_skid_implies_main, skid_valid_q, out_valid_q)
	`MSFD_ASSERT_IMP(a_no_push_when_full, skid_valid_q, !push)
	`MSFD_ASSERT_NXT(a_skid_drains, out_valid_q && !out_stall && skid_valid_q,
		out_valid_q && !skid_valid_q)

endmodule

FILE: hw/rtl/magic_sync_frame_deframer_crc16.sv
// Magic-synchronized frame deframer with CRC-16/CCITT-FALSE check. Bytes enter one
// per cycle on the input transfer; the parser state, the running CRC (one byte-wide
// update per cycle) and the header fields are updated in the cycle of the transfer,
// and the result it causes, if any, is registered in the output stage. The output
// side has a result register plus a skid register, so in_stall rises only when two
// results are held back by out_stall; with out_stall low the block sustains one byte
// per cycle. There is no clearing pass after reset.
// Depends on msfd_pkg, msfd_out_skid and the shared assertion macro header.
`include "magic_sync_frame_deframer_crc16_defines.svh"

module magic_sync_frame_deframer_crc16
	import msfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_enable,
	input  logic [15:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic [7:0]  command,
	output logic [7:0]  sequence_res,
	output logic [15:0] payload_length
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_MAGIC2  = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC_LO  = 3'd4,
		PH_CRC_HI  = 3'd5
	} phase_t;

	logic [15:0] max_len_q;
	phase_t      phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  seq_q, seq_d;
	logic [15:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic        in_accept;
	logic        push;
	result_t     res;
	result_t     out_res;
	logic [15:0] crc_upd;
	logic [15:0] len_hdr;
	logic [16:0] idx_next;

	assign in_accept = in_valid && !in_stall;
	assign crc_upd   = crc16_byte(crc_q, rx_byte);
	assign len_hdr   = {rx_byte, len_q[7:0]};
	assign idx_next  = {1'b0, cnt_q} + 17'd1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write_enable) begin
			max_len_q <= cfg_write_data;
		end
	end

	// Parser next state and the result of the current transfer.
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		cmd_d       = cmd_q;
		seq_d       = seq_q;
		len_d       = len_q;
		crc_d       = crc_q;
		crc_lo_d    = crc_lo_q;
		push        = 1'b0;
		res.kind    = KIND_DATA;
		res.data    = 8'h00;
		res.index   = 16'h0000;
		res.command = cmd_q;
		res.seq_num = seq_q;
		res.length  = len_q;
		if (in_accept) begin
			if (op) begin
				// Stall timeout: abandon the frame, report it once the body has begun.
				phase_d = PH_HUNT;
				if (phase_q == PH_PAYLOAD || phase_q == PH_CRC_LO || phase_q == PH_CRC_HI) begin
					push     = 1'b1;
					res.kind = KIND_ABANDON;
				end
			end else begin
				unique case (phase_q)
					PH_MAGIC2: begin
						if (rx_byte == MAGIC_SECOND) begin
							phase_d = PH_HEADER;
							cnt_d   = 16'h0000;
							crc_d   = CRC_INIT;
						end else if (rx_byte != MAGIC_FIRST) begin
							phase_d = PH_HUNT;
						end
					end
					PH_HEADER: begin
						crc_d = crc_upd;
						case (cnt_q[1:0])
							2'd0:    cmd_d = rx_byte;
							2'd1:    seq_d = rx_byte;
							2'd2:    len_d = {8'h00, rx_byte};
							default: len_d = len_hdr;
						endcase
						if (cnt_q < 16'd3) begin
							cnt_d = idx_next[15:0];
						end else begin
							cnt_d = 16'h0000;
							if (len_hdr > max_len_q) begin
								phase_d = PH_HUNT;
							end else if (len_hdr == 16'h0000) begin
								phase_d = PH_CRC_LO;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						crc_d     = crc_upd;
						push      = 1'b1;
						res.kind  = KIND_DATA;
						res.data  = rx_byte;
						res.index = cnt_q;
						if (idx_next >= {1'b0, len_q}) begin
							phase_d = PH_CRC_LO;
							cnt_d   = 16'h0000;
						end else begin
							cnt_d = idx_next[15:0];
						end
					end
					PH_CRC_LO: begin
						crc_lo_d = rx_byte;
						phase_d  = PH_CRC_HI;
					end
					PH_CRC_HI: begin
						phase_d  = PH_HUNT;
						push     = 1'b1;
						res.kind = ({rx_byte, crc_lo_q} == crc_q) ? KIND_GOOD : KIND_BAD;
					end
					default: begin
						// Hunting, and any phase code without meaning.
						phase_d = (rx_byte == MAGIC_FIRST) ? PH_MAGIC2 : PH_HUNT;
					end
				endcase
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cnt_q    <= 16'h0000;
			cmd_q    <= 8'h00;
			seq_q    <= 8'h00;
			len_q    <= 16'h0000;
			crc_q    <= CRC_INIT;
			crc_lo_q <= 8'h00;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			cmd_q    <= cmd_d;
			seq_q    <= seq_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
		end
	end

	// Result register and skid stage.
	msfd_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign result_kind    = out_res.kind;
	assign payload_byte   = out_res.data;
	assign payload_index  = out_res.index;
	assign command        = out_res.command;
	assign sequence_res   = out_res.seq_num;
	assign payload_length = out_res.length;

	`MSFD_ASSERT_IMP(a_data_only_in_payload, push && res.kind == KIND_DATA, phase_q == PH_PAYLOAD)
	`MSFD_ASSERT_NXT(a_timeout_hunts, in_accept && op, phase_q == PH_HUNT)
	`MSFD_ASSERT_IMP(a_index_in_range, phase_q == PH_PAYLOAD, cnt_q < len_q)

endmodule

FILE: verif/magic_sync_frame_deframer_crc16_tb.sv
// Self-checking testbench for the magic-synchronized frame deframer with CRC-16 check.
// A directed table and random frames are sent under random stalls; results are checked
// against a cycle-free model of the parser. Depends on msfd_pkg and the deframer RTL.
module magic_sync_frame_deframer_crc16_tb;
	import msfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT, PH_SYNC, PH_HDR, PH_BODY, PH_CRC_LO, PH_CRC_HI
	} phase_t;

	// How a transfer's result is checked: by the model, as no result, or as a typed value.
	typedef enum logic [1:0] {
		CHK_MODEL, CHK_NONE, CHK_TYPED
	} chk_t;

	typedef struct {
		logic    o;
		logic [7:0] b;
		chk_t    chk;
		result_t typed;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write_enable;
	logic [15:0] cfg_write_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  command;
	logic [7:0]  sequence_res;
	logic [15:0] payload_length;

	// Check mode of the transfer on the input, updated together with the payload.
	chk_t    in_chk;
	result_t in_typed;

	result_t  pending_results[$];
	dir_row_t dir_tab[$];
	int       err_count = 0;

	// Parser model state.
	phase_t      ph       = PH_HUNT;
	logic [15:0] bcount   = 16'd0;
	logic [7:0]  fcmd     = 8'd0;
	logic [7:0]  fseq     = 8'd0;
	logic [15:0] flen     = 16'd0;
	logic [15:0] run_crc  = CRC_INIT;
	logic [7:0]  crc_lo   = 8'd0;
	logic [15:0] max_len  = MAX_LEN_RESET;

	magic_sync_frame_deframer_crc16 i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.payload_byte     (payload_byte),
		.payload_index    (payload_index),
		.command          (command),
		.sequence_res     (sequence_res),
		.payload_length   (payload_length)
	);

	always #5 clk = ~clk;

	// Bit-serial CRC-16/CCITT-FALSE update, most significant data bit first.
	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] s;
		logic        fb;
		s = c;
		for (int k = 7; k >= 0; k--) begin
			fb = s[15] ^ b[k];
			s = {s[14:0], 1'b0};
			if (fb) begin
				s = s ^ CRC_POLY;
			end
		end
		return s;
	endfunction

	// Advances the parser model by one transfer and returns the result it causes.
	task automatic deframe_step(input logic o, input logic [7:0] b, output logic hit,
		output result_t r);
		hit = 1'b0;
		r = '0;
		if (o) begin
			// A timeout only reports an abandon once the frame body has begun.
			if (ph == PH_BODY || ph == PH_CRC_LO || ph == PH_CRC_HI) begin
				hit = 1'b1;
				r.kind = KIND_ABANDON;
			end
			ph = PH_HUNT;
		end else begin
			case (ph)
				PH_SYNC: begin
					if (b == MAGIC_SECOND) begin
						ph = PH_HDR;
						bcount = 16'd0;
						run_crc = CRC_INIT;
					end else if (b != MAGIC_FIRST) begin
						ph = PH_HUNT;
					end
				end
				PH_HDR: begin
					run_crc = crc_next(run_crc, b);
					case (bcount[1:0])
						2'd0: fcmd = b;
						2'd1: fseq = b;
						2'd2: flen = {8'h00, b};
						default: flen[15:8] = b;
					endcase
					if (bcount < 16'd3) begin
						bcount = bcount + 16'd1;
					end else begin
						bcount = 16'd0;
						if (flen > max_len) begin
							ph = PH_HUNT;
						end else begin
							ph = (flen == 16'd0) ? PH_CRC_LO : PH_BODY;
						end
					end
				end
				PH_BODY: begin
					run_crc = crc_next(run_crc, b);
					hit = 1'b1;
					r.kind = KIND_DATA;
					r.data = b;
					r.index = bcount;
					if (int'(bcount) + 1 >= int'(flen)) begin
						ph = PH_CRC_LO;
						bcount = 16'd0;
					end else begin
						bcount = bcount + 16'd1;
					end
				end
				PH_CRC_LO: begin
					crc_lo = b;
					ph = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					hit = 1'b1;
					r.kind = ({b, crc_lo} == run_crc) ? KIND_GOOD : KIND_BAD;
					ph = PH_HUNT;
				end
				default: begin
					ph = (b == MAGIC_FIRST) ? PH_SYNC : PH_HUNT;
				end
			endcase
		end
		if (hit) begin
			r.command = fcmd;
			r.seq_num = fseq;
			r.length = flen;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			err_count++;
		end
	endtask

	// Output checking first, then prediction for the input transfer of the same edge.
	always @(posedge clk) begin
		result_t want;
		result_t pred;
		logic    hit;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result_kind: expected no result, got %0d", result_kind);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(result_kind));
				check_field("payload_byte", 16'(want.data), 16'(payload_byte));
				check_field("payload_index", want.index, payload_index);
				check_field("command", 16'(want.command), 16'(command));
				check_field("sequence_res", 16'(want.seq_num), 16'(sequence_res));
				check_field("payload_length", want.length, payload_length);
			end
		end
		if (in_valid && !in_stall) begin
			deframe_step(op, rx_byte, hit, pred);
			case (in_chk)
				CHK_TYPED: pending_results.push_back(in_typed);
				CHK_NONE: ;
				default: begin
					if (hit) begin
						pending_results.push_back(pred);
					end
				end
			endcase
		end
	end

	// Receiver stalls: mostly short, a few long, and some long stretches without any.
	initial begin
		int r;
		int n;
		logic lvl;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				lvl = 1'b0;
				n = $urandom_range(1, 6);
			end else if (r < 85) begin
				lvl = 1'b1;
				n = $urandom_range(1, 3);
			end else if (r < 95) begin
				lvl = 1'b1;
				n = $urandom_range(8, 40);
			end else begin
				lvl = 1'b0;
				n = $urandom_range(40, 150);
			end
			out_stall <= lvl;
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		#20000000;
		$display("FAIL magic_sync_frame_deframer_crc16");
		$finish;
	end

	// Drives one transfer after a random gap (none when nogap is set) and returns at the edge that accepts it.
	task automatic send_item(input logic o, input logic [7:0] b, input bit nogap);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (nogap || r < 55) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(6, 30);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Holds the sender with in_valid low until every expected result is in.
	task automatic idle_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [15:0] v);
		idle_wait();
		cfg_write_enable <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		max_len = v;
	endtask

	task automatic dir_add(input logic o, input logic [7:0] b, input chk_t chk,
		input result_t typed);
		dir_row_t row;
		row.o = o;
		row.b = b;
		row.chk = chk;
		row.typed = typed;
		dir_tab.push_back(row);
	endtask

	// Random frame: mostly well formed, with oversized lengths, bad CRCs and truncation.
	task automatic send_frame(inout int done);
		logic [7:0]  fq[$];
		logic [7:0]  bq[$];
		logic [15:0] len;
		logic [15:0] c;
		int          r;
		int          cap;
		int          cut;
		bit          quick;
		r = $urandom_range(0, 99);
		cap = (max_len < 16'd24) ? int'(max_len) : 24;
		if (r < 45) begin
			len = 16'($urandom_range(0, (cap < 4) ? cap : 4));
		end else if (r < 85) begin
			len = 16'($urandom_range(0, cap));
		end else if (r < 95 && max_len != 16'hFFFF) begin
			len = 16'(int'(max_len) + 1 +
				$urandom_range(0, (r < 90) ? 0 : 65534 - int'(max_len)));
		end else begin
			len = (max_len <= 16'd300) ? max_len : 16'($urandom_range(256, 300));
		end
		fq.push_back(MAGIC_FIRST);
		if ($urandom_range(0, 9) == 0) begin
			fq.push_back(MAGIC_FIRST);
		end
		fq.push_back(MAGIC_SECOND);
		bq.push_back(8'($urandom_range(0, 255)));
		bq.push_back(8'($urandom_range(0, 255)));
		bq.push_back(len[7:0]);
		bq.push_back(len[15:8]);
		// An oversized header ends the frame, so nothing follows it.
		if (len <= max_len) begin
			repeat (len) bq.push_back(8'($urandom_range(0, 255)));
			c = CRC_INIT;
			foreach (bq[k]) begin
				c = crc_next(c, bq[k]);
			end
			if ($urandom_range(0, 99) < 12) begin
				c = c ^ (16'h0001 << $urandom_range(0, 15));
			end
			bq.push_back(c[7:0]);
			bq.push_back(c[15:8]);
		end
		foreach (bq[k]) begin
			fq.push_back(bq[k]);
		end
		quick = ($urandom_range(0, 4) == 0);
		cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, fq.size() - 1) : -1;
		foreach (fq[k]) begin
			if (k == cut) begin
				send_item(1'b1, 8'($urandom_range(0, 255)), quick);
				break;
			end
			send_item(1'b0, fq[k], quick);
		end
		done += fq.size();
	endtask

	// Short bursts of line noise and stray magic bytes, usually closed by a timeout.
	task automatic send_noise();
		int n;
		int r;
		n = $urandom_range(1, 6);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 40) begin
				send_item(1'b0, MAGIC_FIRST, 1'b0);
			end else if (r < 50) begin
				send_item(1'b0, MAGIC_SECOND, 1'b0);
			end else begin
				send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			end
		end
		if ($urandom_range(0, 9) < 7) begin
			send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	initial begin
		logic [7:0]  good_body[5];
		logic [15:0] gcrc;
		logic [15:0] limits[5];
		int          done;
		good_body = '{8'hFF, 8'h00, 8'h01, 8'h00, 8'hFF};
		arst_n = 1'b0;
		cfg_write_enable = 1'b0;
		cfg_write_data = 16'd0;
		in_valid = 1'b0;
		op = 1'b0;
		rx_byte = 8'd0;
		in_chk = CHK_MODEL;
		in_typed = '0;

		gcrc = CRC_INIT;
		foreach (good_body[k]) begin
			gcrc = crc_next(gcrc, good_body[k]);
		end

		// Good frame with one payload byte; the repeated first magic byte keeps the sync.
		dir_add(1'b0, MAGIC_FIRST, CHK_MODEL, '0);
		dir_add(1'b0, MAGIC_FIRST, CHK_MODEL, '0);
		dir_add(1'b0, MAGIC_SECOND, CHK_MODEL, '0);
		foreach (good_body[k]) begin
			if (k < 4) begin
				dir_add(1'b0, good_body[k], CHK_MODEL, '0);
			end
		end
		dir_add(1'b0, 8'hFF, CHK_TYPED,
			result_t'{KIND_DATA, 8'hFF, 16'd0, 8'hFF, 8'h00, 16'd1});
		dir_add(1'b0, gcrc[7:0], CHK_MODEL, '0);
		dir_add(1'b0, gcrc[15:8], CHK_TYPED,
			result_t'{KIND_GOOD, 8'h00, 16'd0, 8'hFF, 8'h00, 16'd1});
		// Length one above the maximum drops to hunting, so the timeout reports nothing.
		dir_add(1'b0, MAGIC_FIRST, CHK_MODEL, '0);
		dir_add(1'b0, MAGIC_SECOND, CHK_MODEL, '0);
		dir_add(1'b0, 8'h12, CHK_MODEL, '0);
		dir_add(1'b0, 8'h34, CHK_MODEL, '0);
		dir_add(1'b0, 8'h01, CHK_MODEL, '0);
		dir_add(1'b0, 8'h10, CHK_MODEL, '0);
		dir_add(1'b1, 8'h00, CHK_NONE, '0);
		// Zero-length frame abandoned by a timeout where the CRC should start.
		dir_add(1'b0, MAGIC_FIRST, CHK_MODEL, '0);
		dir_add(1'b0, MAGIC_SECOND, CHK_MODEL, '0);
		dir_add(1'b0, 8'h56, CHK_MODEL, '0);
		dir_add(1'b0, 8'h78, CHK_MODEL, '0);
		dir_add(1'b0, 8'h00, CHK_MODEL, '0);
		dir_add(1'b0, 8'h00, CHK_MODEL, '0);
		dir_add(1'b1, 8'hFF, CHK_TYPED,
			result_t'{KIND_ABANDON, 8'h00, 16'd0, 8'h56, 8'h78, 16'd0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with the reset maximum length.
		foreach (dir_tab[k]) begin
			in_chk <= dir_tab[k].chk;
			in_typed <= dir_tab[k].typed;
			send_item(dir_tab[k].o, dir_tab[k].b, 1'($urandom_range(0, 1)));
		end
		in_chk <= CHK_MODEL;
		in_typed <= '0;

		// Random part over several maximum lengths, among them 1 and the largest, 16'hFFFF.
		limits = '{16'd1, 16'hFFFF, 16'd8, 16'($urandom_range(2, 600)), MAX_LEN_RESET};
		foreach (limits[p]) begin
			set_max_len(limits[p]);
			done = 0;
			while (done < 340) begin
				if ($urandom_range(0, 99) < 25) begin
					send_noise();
				end else begin
					send_frame(done);
				end
			end
		end

		idle_wait();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS magic_sync_frame_deframer_crc16");
		end else begin
			$display("FAIL magic_sync_frame_deframer_crc16");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/msfd_pkg.sv
hw/rtl/msfd_out_skid.sv
hw/rtl/magic_sync_frame_deframer_crc16.sv
verif/magic_sync_frame_deframer_crc16_tb.sv
